// ===== sv/rbsi_pkg.sv =====
// Shared widths, codes and payload types for the ray/box slab test.
package rbsi_pkg;

	localparam int COORD_W = 32;
	localparam int FRAC_W  = 16;
	localparam int THR_W   = 16;
	localparam int ENTRY_W = 31;
	localparam int AXES    = 3;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int DEN_W   = COORD_W;
	localparam int NUM_W   = DIFF_W + FRAC_W;
	localparam int QUO_W   = NUM_W;
	localparam int DIST_W  = QUO_W + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		OUT_HIT         = 2'd0,
		OUT_INVALID_RAY = 2'd1,
		OUT_INVALID_BOX = 2'd2,
		OUT_MISS        = 2'd3
	} outcome_t;

	// classified test waiting for the divider pipeline
	typedef struct packed {
		logic [AXES-1:0]              active;
		logic [AXES-1:0]              neg_lo;
		logic [AXES-1:0]              neg_hi;
		logic [AXES-1:0][DIFF_W-1:0]  mag_lo;
		logic [AXES-1:0][DIFF_W-1:0]  mag_hi;
		logic [AXES-1:0][DEN_W-1:0]   mag_dir;
		logic                         pre_fail;
		outcome_t                     pre_code;
	} item_t;

	// sideband that rides along the divider stages
	typedef struct packed {
		logic [AXES-1:0] active;
		logic [AXES-1:0] neg_lo;
		logic [AXES-1:0] neg_hi;
		logic            pre_fail;
		outcome_t        pre_code;
	} side_t;

endpackage

// ===== sv/rbsi_front.sv =====
// Front end: input register, threshold register and per-axis classification.
module rbsi_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [rbsi_pkg::THR_W-1:0]            cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [rbsi_pkg::COORD_W-1:0]   org [rbsi_pkg::AXES],
	input  logic signed [rbsi_pkg::COORD_W-1:0]   dir [rbsi_pkg::AXES],
	input  logic signed [rbsi_pkg::COORD_W-1:0]   lo  [rbsi_pkg::AXES],
	input  logic signed [rbsi_pkg::COORD_W-1:0]   hi  [rbsi_pkg::AXES],
	input  logic                                  fifo_full,
	output logic                                  push,
	output rbsi_pkg::item_t                       item
);

	logic [rbsi_pkg::THR_W-1:0] thr_q;
	logic                       valid_s1;
	rbsi_pkg::item_t            item_s1;
	rbsi_pkg::item_t            cls;

	logic [rbsi_pkg::AXES-1:0]  par_miss;
	logic [rbsi_pkg::AXES-1:0]  box_bad;
	logic                       ray_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	always_comb begin
		logic signed [rbsi_pkg::DIFF_W-1:0] dlo;
		logic signed [rbsi_pkg::DIFF_W-1:0] dhi;
		logic [rbsi_pkg::DEN_W-1:0]         mdir;
		cls = '0;
		ray_bad = 1'b1;
		for (int a = 0; a < rbsi_pkg::AXES; a++) begin
			dlo  = {lo[a][rbsi_pkg::COORD_W-1], lo[a]} - {org[a][rbsi_pkg::COORD_W-1], org[a]};
			dhi  = {hi[a][rbsi_pkg::COORD_W-1], hi[a]} - {org[a][rbsi_pkg::COORD_W-1], org[a]};
			mdir = dir[a][rbsi_pkg::COORD_W-1] ? rbsi_pkg::DEN_W'(-dir[a]) : dir[a];
			if (dir[a] != '0)
				ray_bad = 1'b0;
			box_bad[a]  = lo[a] > hi[a];
			cls.active[a] = mdir > rbsi_pkg::DEN_W'(thr_q);
			par_miss[a] = !cls.active[a] && (org[a] < lo[a] || org[a] > hi[a]);
			cls.neg_lo[a]  = dlo[rbsi_pkg::DIFF_W-1] ^ dir[a][rbsi_pkg::COORD_W-1];
			cls.neg_hi[a]  = dhi[rbsi_pkg::DIFF_W-1] ^ dir[a][rbsi_pkg::COORD_W-1];
			cls.mag_lo[a]  = dlo[rbsi_pkg::DIFF_W-1] ? -dlo : dlo;
			cls.mag_hi[a]  = dhi[rbsi_pkg::DIFF_W-1] ? -dhi : dhi;
			cls.mag_dir[a] = mdir;
		end
		priority if (ray_bad) begin
			cls.pre_fail = 1'b1;
			cls.pre_code = rbsi_pkg::OUT_INVALID_RAY;
		end else if (|box_bad) begin
			cls.pre_fail = 1'b1;
			cls.pre_code = rbsi_pkg::OUT_INVALID_BOX;
		end else if (|par_miss) begin
			cls.pre_fail = 1'b1;
			cls.pre_code = rbsi_pkg::OUT_MISS;
		end else begin
			cls.pre_fail = 1'b0;
			cls.pre_code = rbsi_pkg::OUT_HIT;
		end
	end

	assign in_stall = valid_s1 && fifo_full;
	assign push     = valid_s1 && !fifo_full;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= cls;
		end
	end

endmodule

// ===== sv/rbsi_fifo.sv =====
// Short queue between classification and the divider pipeline.
module rbsi_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rbsi_pkg::item_t wr_item,
	output logic            full,
	input  logic            pop,
	output logic            rd_valid,
	output rbsi_pkg::item_t rd_item
);

	rbsi_pkg::item_t                mem_q [rbsi_pkg::FIFO_DEPTH];
	logic [rbsi_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [rbsi_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [rbsi_pkg::FIFO_AW:0]     count_q;

	assign full     = count_q == (rbsi_pkg::FIFO_AW+1)'(rbsi_pkg::FIFO_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!rd_valid |-> !pop) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (rbsi_pkg::FIFO_AW+1)'(rbsi_pkg::FIFO_DEPTH))
		else $error("queue count out of range");

endmodule

// ===== sv/rbsi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rbsi_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [rbsi_pkg::NUM_W-1:0]  num,
	input  logic [rbsi_pkg::DEN_W-1:0]  den,
	output logic [rbsi_pkg::QUO_W-1:0]  quo
);

	localparam int QW = rbsi_pkg::QUO_W;
	localparam int DW = rbsi_pkg::DEN_W;
	localparam int NW = rbsi_pkg::NUM_W;

	logic [DW-1:0] rem_s [1:QW];
	logic [QW-1:0] quo_s [1:QW];
	logic [NW-1:0] num_s [1:QW];
	logic [DW-1:0] den_s [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [QW-1:0] quo_in;
		logic [NW-1:0] num_in;
		logic [DW-1:0] den_in;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = '0;
			assign num_in = num;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign quo_in = quo_s[k];
			assign num_in = num_s[k];
			assign den_in = den_s[k];
		end

		assign trial = {rem_in, num_in[NW-1-k]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
				quo_s[k+1] <= {quo_in[QW-2:0], ge};
				num_s[k+1] <= num_in;
				den_s[k+1] <= den_in;
			end
		end
	end

	assign quo = quo_s[QW];

endmodule

// ===== sv/rbsi_back.sv =====
// Back end: six divider lanes, slab ordering, entry/exit reduction, result register.
module rbsi_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  rbsi_pkg::item_t                   q_item,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [rbsi_pkg::ENTRY_W-1:0]      entry_distance,
	output logic [1:0]                        outcome
);

	localparam int QW = rbsi_pkg::QUO_W;
	localparam int DW = rbsi_pkg::DIST_W;
	localparam int NA = rbsi_pkg::AXES;
	localparam logic signed [DW-1:0] DIST_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] ENTRY_MAX = DW'({rbsi_pkg::ENTRY_W{1'b1}});

	logic en;
	logic [QW-1:0] q_lo [NA];
	logic [QW-1:0] q_hi [NA];

	logic          valid_s [1:QW];
	rbsi_pkg::side_t side_s [1:QW];

	logic                   valid_p1;
	rbsi_pkg::side_t        side_p1;
	logic signed [DW-1:0]   near_p1 [NA];
	logic signed [DW-1:0]   far_p1  [NA];

	logic                   valid_p2;
	rbsi_pkg::side_t        side_p2;
	logic signed [DW-1:0]   entry_p2;
	logic signed [DW-1:0]   exit_p2;
	logic                   exit_set_p2;

	logic                   out_valid_q;
	logic                   hit_q;
	logic [rbsi_pkg::ENTRY_W-1:0] entry_q;
	rbsi_pkg::outcome_t     outcome_q;

	// whole pipeline advances together; the result register frees on transfer
	assign en  = !out_valid_q || !out_stall;
	assign pop = q_valid && en;

	for (genvar a = 0; a < NA; a++) begin : g_lane
		rbsi_div u_div_lo (
			.clk (clk),
			.en  (en),
			.num ({q_item.mag_lo[a], {rbsi_pkg::FRAC_W{1'b0}}}),
			.den (q_item.mag_dir[a]),
			.quo (q_lo[a])
		);
		rbsi_div u_div_hi (
			.clk (clk),
			.en  (en),
			.num ({q_item.mag_hi[a], {rbsi_pkg::FRAC_W{1'b0}}}),
			.den (q_item.mag_dir[a]),
			.quo (q_hi[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= QW; k++)
				valid_s[k] <= 1'b0;
			valid_p1    <= 1'b0;
			valid_p2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s[1] <= pop;
			for (int k = 2; k <= QW; k++)
				valid_s[k] <= valid_s[k-1];
			valid_p1    <= valid_s[QW];
			valid_p2    <= valid_p1;
			out_valid_q <= valid_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= '{active:   q_item.active,
			               neg_lo:   q_item.neg_lo,
			               neg_hi:   q_item.neg_hi,
			               pre_fail: q_item.pre_fail,
			               pre_code: q_item.pre_code};
			for (int k = 2; k <= QW; k++)
				side_s[k] <= side_s[k-1];
		end
	end

	// signed slab distances, ordered near/far
	always_ff @(posedge clk) begin
		logic signed [DW-1:0] dlo;
		logic signed [DW-1:0] dhi;
		if (en) begin
			side_p1 <= side_s[QW];
			for (int a = 0; a < NA; a++) begin
				dlo = side_s[QW].neg_lo[a] ? -{1'b0, q_lo[a]} : {1'b0, q_lo[a]};
				dhi = side_s[QW].neg_hi[a] ? -{1'b0, q_hi[a]} : {1'b0, q_hi[a]};
				near_p1[a] <= (dlo > dhi) ? dhi : dlo;
				far_p1[a]  <= (dlo > dhi) ? dlo : dhi;
			end
		end
	end

	// entry is the largest near (floored at zero), exit the smallest far
	always_ff @(posedge clk) begin
		logic signed [DW-1:0] ent;
		logic signed [DW-1:0] ext;
		if (en) begin
			ent = '0;
			ext = DIST_MAX;
			for (int a = 0; a < NA; a++) begin
				if (side_p1.active[a] && near_p1[a] > ent)
					ent = near_p1[a];
				if (side_p1.active[a] && far_p1[a] < ext)
					ext = far_p1[a];
			end
			side_p2     <= side_p1;
			entry_p2    <= ent;
			exit_p2     <= ext;
			exit_set_p2 <= |side_p1.active;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (side_p2.pre_fail) begin
				hit_q     <= 1'b0;
				entry_q   <= '0;
				outcome_q <= side_p2.pre_code;
			end else if (entry_p2 > exit_p2 || (exit_set_p2 && exit_p2 < 0)) begin
				hit_q     <= 1'b0;
				entry_q   <= '0;
				outcome_q <= rbsi_pkg::OUT_MISS;
			end else begin
				hit_q     <= 1'b1;
				entry_q   <= (entry_p2 > ENTRY_MAX) ? ENTRY_MAX[rbsi_pkg::ENTRY_W-1:0]
				                                    : entry_p2[rbsi_pkg::ENTRY_W-1:0];
				outcome_q <= rbsi_pkg::OUT_HIT;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign entry_distance = entry_q;
	assign outcome        = outcome_q;

	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (hit_q == (outcome_q == rbsi_pkg::OUT_HIT)))
		else $error("hit flag disagrees with outcome");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !hit_q |-> entry_q == '0)
		else $error("nonzero entry on a non-hit");
	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> $stable(valid_p2) && $stable(valid_s[QW]))
		else $error("pipeline moved while result stalled");

endmodule

// ===== sv/ray_box_slab_intersect.sv =====
// Throughput: one ray/box test per cycle unless out_stall holds the pipeline;
// the 49-stage divider lanes set the depth.
// A 4-entry queue decouples classification from the divider pipeline.
// Reset (arst_n low) empties the pipeline and queue and clears the threshold to 0.
// Top level: ray versus axis-aligned box slab test on Q16.16 inputs.
module ray_box_slab_intersect (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [rbsi_pkg::THR_W-1:0]           cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [rbsi_pkg::COORD_W-1:0]  origin_x,
	input  logic signed [rbsi_pkg::COORD_W-1:0]  origin_y,
	input  logic signed [rbsi_pkg::COORD_W-1:0]  origin_z,
	input  logic signed [rbsi_pkg::COORD_W-1:0]  dir_x,
	input  logic signed [rbsi_pkg::COORD_W-1:0]  dir_y,
	input  logic signed [rbsi_pkg::COORD_W-1:0]  dir_z,
	input  logic signed [rbsi_pkg::COORD_W-1:0]  box_min_x,
	input  logic signed [rbsi_pkg::COORD_W-1:0]  box_min_y,
	input  logic signed [rbsi_pkg::COORD_W-1:0]  box_min_z,
	input  logic signed [rbsi_pkg::COORD_W-1:0]  box_max_x,
	input  logic signed [rbsi_pkg::COORD_W-1:0]  box_max_y,
	input  logic signed [rbsi_pkg::COORD_W-1:0]  box_max_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 hit,
	output logic [rbsi_pkg::ENTRY_W-1:0]         entry_distance,
	output logic [1:0]                           outcome
);

	logic signed [rbsi_pkg::COORD_W-1:0] org [rbsi_pkg::AXES];
	logic signed [rbsi_pkg::COORD_W-1:0] dir [rbsi_pkg::AXES];
	logic signed [rbsi_pkg::COORD_W-1:0] lo  [rbsi_pkg::AXES];
	logic signed [rbsi_pkg::COORD_W-1:0] hi  [rbsi_pkg::AXES];

	logic            push;
	logic            fifo_full;
	rbsi_pkg::item_t wr_item;
	logic            pop;
	logic            q_valid;
	rbsi_pkg::item_t q_item;

	assign org = '{origin_x, origin_y, origin_z};
	assign dir = '{dir_x, dir_y, dir_z};
	assign lo  = '{box_min_x, box_min_y, box_min_z};
	assign hi  = '{box_max_x, box_max_y, box_max_z};

	rbsi_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.org         (org),
		.dir         (dir),
		.lo          (lo),
		.hi          (hi),
		.fifo_full   (fifo_full),
		.push        (push),
		.item        (wr_item)
	);

	rbsi_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (wr_item),
		.full     (fifo_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_item  (q_item)
	);

	rbsi_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.entry_distance (entry_distance),
		.outcome        (outcome)
	);

endmodule
